FILE: hw/rtl/sva_pkg.sv
// ----------------------------------------------------------------------------
// sva_pkg
// Shared types and constants for the slot vector aggregator.
// ----------------------------------------------------------------------------
package sva_pkg;

  localparam int TAG_W   = 16;
  localparam int SLOT_TW = 15;  // slot tag bits inside pool_tag
  localparam int SEQ_W   = 32;
  localparam int IDX_W   = 8;
  localparam int VAL_W   = 32;
  localparam int EXP_W   = 16;
  localparam int CNT_W   = 7;
  localparam int CFG_W   = 15;

  localparam logic signed [EXP_W-1:0] EXP_RESET = -16'sd126;

  typedef enum logic [0:0] {
    CFG_WORKER_COUNT = 1'b0,
    CFG_SLOT_BASE    = 1'b1
  } sva_cfg_idx_t;

  typedef struct packed {
    logic [TAG_W-1:0]        pool_tag;
    logic [SEQ_W-1:0]        sequence_id;
    logic [IDX_W-1:0]        element_index;
    logic signed [VAL_W-1:0] update_value;
    logic signed [EXP_W-1:0] exponent;
    logic                    last_element;
  } sva_in_t;

  typedef struct packed {
    logic [TAG_W-1:0]        out_pool_tag;
    logic [SEQ_W-1:0]        out_sequence_id;
    logic [IDX_W-1:0]        out_element_index;
    logic signed [VAL_W-1:0] sum_value;
    logic signed [EXP_W-1:0] max_exponent;
    logic                    out_last;
    logic                    index_error;
  } sva_out_t;

  // Per-slot word: running max exponent and completed packet count
  typedef struct packed {
    logic signed [EXP_W-1:0] exponent;
    logic [CNT_W-1:0]        count;
  } sva_slot_t;

endpackage

FILE: hw/rtl/sva_ram.sv
// ----------------------------------------------------------------------------
// sva_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sva_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/slot_vector_aggregator.sv
// ----------------------------------------------------------------------------
// slot_vector_aggregator
// Per-slot, per-element summation of worker update vectors; emits the final
// sums while the last worker's packet streams through, and flags out-of-range items with index_error.
// ----------------------------------------------------------------------------
//  channel | ports                          | transaction
//  --------+--------------------------------+-------------------------------
//  input   | start, busy, in_data           | start && !busy at clk edge
//  result  | out_valid, out_data            | one-cycle strobe, no backpressure
//  config  | cfg_we, cfg_index, cfg_wdata   | cfg_we at clk edge
//
//  One item per cycle while busy is low; each result is registered through stage 1 and the result register.
//  Accumulator and slot memories are read at accept and written back in the
//  following cycle; back-to-back hits on the same entry are forwarded.
//  After reset a clearing pass over all SLOTS*UPDATES accumulator cells and all slot words runs with busy high.
//  Results are strobed and never stall the pipeline.
// ----------------------------------------------------------------------------
module slot_vector_aggregator
  import sva_pkg::*;
#(
  parameter int SLOTS   = 256,
  parameter int UPDATES = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  output logic         busy,
  input  sva_in_t      in_data,
  output logic         out_valid,
  output sva_out_t     out_data,
  input  logic         cfg_we,
  input  sva_cfg_idx_t cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata
);

  localparam int ACC_DEPTH = SLOTS * UPDATES;
  localparam int CELL_W    = ACC_DEPTH > 1 ? $clog2(ACC_DEPTH) : 1;
  localparam int SLOT_W    = SLOTS > 1 ? $clog2(SLOTS) : 1;
  localparam int CELL_XW   = SLOT_W + IDX_W + 1;

  // configuration
  logic [CNT_W-1:0]   worker_count_r;
  logic [SLOT_TW-1:0] slot_base_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      worker_count_r <= CNT_W'(1);
      slot_base_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WORKER_COUNT: worker_count_r <= cfg_wdata[CNT_W-1:0];
        CFG_SLOT_BASE:    slot_base_r    <= cfg_wdata[SLOT_TW-1:0];
        default:          ;
      endcase
    end
  end

  // clearing pass
  logic              clearing_r;
  logic [CELL_W-1:0] clr_cnt_r;
  logic              clr_slot_en;

  assign clr_slot_en = ({1'b0, clr_cnt_r} < (CELL_W+1)'(SLOTS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clearing_r) begin
      clr_cnt_r <= clr_cnt_r + CELL_W'(1);
      if (clr_cnt_r == CELL_W'(ACC_DEPTH - 1)) begin
        clearing_r <= 1'b0;
      end
    end
  end

  assign busy = clearing_r;

  // address decode at accept
  logic               accept;
  logic [SLOT_TW:0]   in_diff;
  logic               in_ok;
  logic [SLOT_W-1:0]  in_slot;
  logic [CELL_XW-1:0] in_cell_full;
  logic [CELL_W-1:0]  in_cell;

  assign accept       = start && !busy;
  assign in_diff      = {1'b0, in_data.pool_tag[SLOT_TW-1:0]} - {1'b0, slot_base_r};
  assign in_ok        = !in_diff[SLOT_TW] && (in_diff < (SLOT_TW+1)'(SLOTS))
                        && ({1'b0, in_data.element_index} < (IDX_W+1)'(UPDATES));
  assign in_slot      = in_diff[SLOT_W-1:0];
  assign in_cell_full = CELL_XW'(in_slot) * CELL_XW'(UPDATES)
                        + CELL_XW'(in_data.element_index);
  assign in_cell      = in_cell_full[CELL_W-1:0];

  // stage 1: memory data available
  logic              s1_valid_r;
  logic              s1_ok_r;
  sva_in_t           s1_item_r;
  logic [SLOT_W-1:0] s1_slot_r;
  logic [CELL_W-1:0] s1_cell_r;
  logic              fwd_acc_hit_r;
  logic [VAL_W-1:0]  fwd_acc_r;
  logic              fwd_slot_hit_r;
  sva_slot_t         fwd_slot_r;

  logic [VAL_W-1:0]  acc_q;
  sva_slot_t         slot_q;

  logic              s1_wr;
  logic [VAL_W-1:0]  acc_cur;
  sva_slot_t         slot_cur;
  logic [VAL_W-1:0]  sum;
  logic signed [EXP_W-1:0] mx;
  logic              final_pkt;
  logic [VAL_W-1:0]  acc_new;
  sva_slot_t         slot_new;

  assign s1_wr    = s1_valid_r && s1_ok_r;
  assign acc_cur  = fwd_acc_hit_r  ? fwd_acc_r  : acc_q;
  assign slot_cur = fwd_slot_hit_r ? fwd_slot_r : slot_q;
  assign sum      = acc_cur + s1_item_r.update_value;
  assign mx       = (s1_item_r.exponent > slot_cur.exponent) ? s1_item_r.exponent
                                                             : slot_cur.exponent;
  // worker_count of zero behaves as one
  assign final_pkt = ({1'b0, slot_cur.count} + (CNT_W+1)'(1)) >= {1'b0, worker_count_r};
  assign acc_new   = final_pkt ? '0 : sum;

  always_comb begin
    slot_new.exponent = mx;
    slot_new.count    = slot_cur.count;
    if (s1_item_r.last_element) begin
      if (final_pkt) begin
        slot_new.exponent = EXP_RESET;
        slot_new.count    = '0;
      end else begin
        slot_new.count    = slot_cur.count + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r     <= 1'b0;
      fwd_acc_hit_r  <= 1'b0;
      fwd_slot_hit_r <= 1'b0;
    end else begin
      s1_valid_r     <= accept;
      fwd_acc_hit_r  <= accept && s1_wr && (s1_cell_r == in_cell);
      fwd_slot_hit_r <= accept && s1_wr && (s1_slot_r == in_slot);
    end
  end

  always_ff @(posedge clk) begin
    s1_ok_r    <= in_ok;
    s1_item_r  <= in_data;
    s1_slot_r  <= in_slot;
    s1_cell_r  <= in_cell;
    fwd_acc_r  <= acc_new;
    fwd_slot_r <= slot_new;
  end

  // memories
  logic              acc_we;
  logic [CELL_W-1:0] acc_waddr;
  logic [VAL_W-1:0]  acc_wdata;
  logic              slot_we;
  logic [SLOT_W-1:0] slot_waddr;
  sva_slot_t         slot_wdata;

  assign acc_we     = clearing_r || s1_wr;
  assign acc_waddr  = clearing_r ? clr_cnt_r : s1_cell_r;
  assign acc_wdata  = clearing_r ? '0 : acc_new;
  assign slot_we    = clearing_r ? clr_slot_en : s1_wr;
  assign slot_waddr = clearing_r ? clr_cnt_r[SLOT_W-1:0] : s1_slot_r;
  assign slot_wdata = clearing_r ? sva_slot_t'{exponent: EXP_RESET, count: '0} : slot_new;

  sva_ram #(
    .WIDTH (VAL_W),
    .DEPTH (ACC_DEPTH)
  ) u_acc_ram (
    .clk   (clk),
    .we    (acc_we),
    .waddr (acc_waddr),
    .wdata (acc_wdata),
    .raddr (in_cell),
    .rdata (acc_q)
  );

  sva_ram #(
    .WIDTH ($bits(sva_slot_t)),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .raddr (in_slot),
    .rdata (slot_q)
  );

  // result register
  logic     out_valid_r;
  sva_out_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s1_valid_r && (!s1_ok_r || final_pkt);
    end
  end

  always_ff @(posedge clk) begin
    out_data_r.out_pool_tag      <= s1_item_r.pool_tag;
    out_data_r.out_sequence_id   <= s1_item_r.sequence_id;
    out_data_r.out_element_index <= s1_item_r.element_index;
    out_data_r.out_last          <= s1_item_r.last_element;
    out_data_r.index_error       <= !s1_ok_r;
    out_data_r.sum_value         <= s1_ok_r ? sum : '0;
    out_data_r.max_exponent      <= s1_ok_r ? mx  : '0;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: hw/rtl/sva_checker.sv
// ----------------------------------------------------------------------------
// sva_checker
// Port-level checks for the slot vector aggregator, bound to the top level.
// ----------------------------------------------------------------------------
module sva_checker
  import sva_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     start,
  input logic     busy,
  input logic     out_valid,
  input sva_out_t out_data
);

  // every result traces back to an accepted input transaction
  a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 2))
    else $error("result without matching input transaction");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.index_error) |->
      (out_data.sum_value == '0 && out_data.max_exponent == '0))
    else $error("dropped item carries nonzero payload");

  a_exp_floor: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.index_error) |-> (out_data.max_exponent >= EXP_RESET))
    else $error("max exponent below reset floor");

  // clearing pass holds off input right after reset
  a_clear_after_reset: assert property (@(posedge clk)
    (rst_n && $past(!rst_n)) |-> busy)
    else $error("busy not raised after reset");

endmodule

bind slot_vector_aggregator sva_checker u_sva_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);
